FILE: sv/bucketed_fingerprint_set_top_defines.svh
// Assertion macros shared by the project.
`ifndef BUCKETED_FINGERPRINT_SET_TOP_DEFINES_SVH
`define BUCKETED_FINGERPRINT_SET_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define BFS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define BFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define BFS_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define BFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: sv/bfs_pkg.sv
package bfs_pkg;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_H_RD,
      ST_H_CHK,
      ST_G_BEGIN,
      ST_G_FILL,
      ST_G_N,
      ST_G_RD,
      ST_G_PUSH,
      ST_G_END_LO,
      ST_G_END_HI,
      ST_G_SWAP,
      ST_K_FILL,
      ST_K_N,
      ST_K_RD,
      ST_K_CMP,
      ST_DONE
   } state_type;

   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_QUERY  = 1'b1;

   typedef struct packed {
      logic latch;
      logic bkt_clr;
      logic bkt_inc;
      logic idx_clr;
      logic idx_inc;
      logic fill_rd_bkt;
      logic fill_rd_key;
      logic fill_hold;
      logic ent_rd_bkt;
      logic ent_rd_key;
      logic grow_begin;
      logic grow_push;
      logic fill_wr_lo;
      logic fill_wr_hi;
      logic grow_swap;
      logic push_write;
      logic set_found;
      logic set_fail;
      logic out_load;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic fill_hot;
      logic last_bkt;
      logic idx_done;
      logic match;
      logic full;
      logic grow_ok;
      logic rsp_busy;
   } sts_type;

endpackage

FILE: sv/bucketed_fingerprint_set_top.sv
// Channel    | Dir | Signals                         | Contents
// req_       | in  | tvalid tready tdata[31:0] tuser | fingerprint, request type
// rsp_       | out | tvalid tready tdata[15:0]       | found, insert_failed, bucket count
// csr_       | in  | wr_en wr_data[4:0]              | page_capacity
//
// One request is worked on at a time. An insert first scans the fill of
// every bucket in use until it finds a hot one, then works like a query on
// its own bucket; the fill memory and entry memory each read one word per
// cycle. A growth pass reads the fill of every old bucket and copies each
// stored entry that still fits to the other bank.
// Reset is synchronous; it clears the fill valid bits, so no clearing pass
// is needed. A result that is not taken stalls the next one, but a new
// request is already taken while the result waits.
`include "bucketed_fingerprint_set_top_defines.svh"

module bucketed_fingerprint_set_top #(
   parameter int MAX_BUCKETS     = 64,
   parameter int PAGE_DEPTH      = 16,
   parameter int INITIAL_BUCKETS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] fingerprint
   input  logic        req_tuser,   // [0] req_type: 0 insert, 1 query
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [0] found, [1] insert_failed, [8:2] bucket_count_now
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data
);

   bfs_pkg::cmd_type cmd;
   bfs_pkg::sts_type sts;
   logic             rsp_found;
   logic             rsp_failed;
   logic [6:0]       rsp_count;

   // The controller sequences the scans; the datapath holds the memories.
   bfs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_ready  (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bfs_dp #(
      .MAX_BUCKETS     (MAX_BUCKETS),
      .PAGE_DEPTH      (PAGE_DEPTH),
      .INITIAL_BUCKETS (INITIAL_BUCKETS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_type    (req_tuser),
      .req_fp      (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp_tready  (rsp_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_found   (rsp_found),
      .rsp_failed  (rsp_failed),
      .rsp_count   (rsp_count),
      .cmd         (cmd),
      .sts         (sts)
   );

   assign rsp_tdata = {7'd0, rsp_count, rsp_failed, rsp_found};

   // A request never reports both a hit and a failed insert.
   `BFS_ASSERT_IMPL(a_found_xor_fail, clock, reset, rsp_tvalid, !(rsp_tdata[0] && rsp_tdata[1]), "found and insert_failed both set")
   // A request is never taken in the cycle after one was taken.
   `BFS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request taken while busy")

endmodule

FILE: sv/bfs_ctrl.sv
module bfs_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_ready,
   input  bfs_pkg::sts_type sts,
   output bfs_pkg::cmd_type cmd
);

   bfs_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfs_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         bfs_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = bfs_pkg::ST_H_RD;
            end
         end
         bfs_pkg::ST_H_RD: begin
            state_in = sts.is_query ? bfs_pkg::ST_K_FILL : bfs_pkg::ST_H_CHK;
         end
         bfs_pkg::ST_H_CHK: begin
            if (sts.fill_hot) begin
               state_in = sts.grow_ok ? bfs_pkg::ST_G_BEGIN : bfs_pkg::ST_DONE;
            end else if (sts.last_bkt) begin
               state_in = bfs_pkg::ST_K_FILL;
            end else begin
               state_in = bfs_pkg::ST_H_RD;
            end
         end
         bfs_pkg::ST_G_BEGIN:  state_in = bfs_pkg::ST_G_FILL;
         bfs_pkg::ST_G_FILL:   state_in = bfs_pkg::ST_G_N;
         bfs_pkg::ST_G_N:      state_in = bfs_pkg::ST_G_RD;
         bfs_pkg::ST_G_RD: begin
            state_in = sts.idx_done ? bfs_pkg::ST_G_END_LO : bfs_pkg::ST_G_PUSH;
         end
         bfs_pkg::ST_G_PUSH:   state_in = bfs_pkg::ST_G_RD;
         bfs_pkg::ST_G_END_LO: state_in = bfs_pkg::ST_G_END_HI;
         bfs_pkg::ST_G_END_HI: begin
            state_in = sts.last_bkt ? bfs_pkg::ST_G_SWAP : bfs_pkg::ST_G_FILL;
         end
         bfs_pkg::ST_G_SWAP:   state_in = bfs_pkg::ST_K_FILL;
         bfs_pkg::ST_K_FILL:   state_in = bfs_pkg::ST_K_N;
         bfs_pkg::ST_K_N:      state_in = bfs_pkg::ST_K_RD;
         bfs_pkg::ST_K_RD: begin
            if (!sts.is_query && sts.full) begin
               state_in = bfs_pkg::ST_DONE;
            end else if (sts.idx_done) begin
               state_in = bfs_pkg::ST_DONE;
            end else begin
               state_in = bfs_pkg::ST_K_CMP;
            end
         end
         bfs_pkg::ST_K_CMP: begin
            state_in = sts.match ? bfs_pkg::ST_DONE : bfs_pkg::ST_K_RD;
         end
         bfs_pkg::ST_DONE: begin
            if (!sts.rsp_busy) begin
               state_in = bfs_pkg::ST_IDLE;
            end
         end
         default: state_in = bfs_pkg::ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         bfs_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.latch = req_tvalid;
         end
         bfs_pkg::ST_H_RD: begin
            cmd.fill_rd_bkt = 1'b1;
         end
         bfs_pkg::ST_H_CHK: begin
            if (sts.fill_hot) begin
               cmd.set_fail = !sts.grow_ok;
            end else if (!sts.last_bkt) begin
               cmd.bkt_inc = 1'b1;
            end
         end
         bfs_pkg::ST_G_BEGIN: begin
            cmd.grow_begin = 1'b1;
            cmd.bkt_clr    = 1'b1;
         end
         bfs_pkg::ST_G_FILL: begin
            cmd.fill_rd_bkt = 1'b1;
         end
         bfs_pkg::ST_G_N: begin
            cmd.fill_hold = 1'b1;
            cmd.idx_clr   = 1'b1;
         end
         bfs_pkg::ST_G_RD: begin
            if (!sts.idx_done) begin
               cmd.ent_rd_bkt = 1'b1;
               cmd.idx_inc    = 1'b1;
            end
         end
         bfs_pkg::ST_G_PUSH: begin
            cmd.grow_push = 1'b1;
         end
         bfs_pkg::ST_G_END_LO: begin
            cmd.fill_wr_lo = 1'b1;
         end
         bfs_pkg::ST_G_END_HI: begin
            cmd.fill_wr_hi = 1'b1;
            cmd.bkt_inc    = !sts.last_bkt;
         end
         bfs_pkg::ST_G_SWAP: begin
            cmd.grow_swap = 1'b1;
         end
         bfs_pkg::ST_K_FILL: begin
            cmd.fill_rd_key = 1'b1;
         end
         bfs_pkg::ST_K_N: begin
            cmd.fill_hold = 1'b1;
            cmd.idx_clr   = 1'b1;
         end
         bfs_pkg::ST_K_RD: begin
            if (!sts.is_query && sts.full) begin
               cmd.set_fail = 1'b1;
            end else if (sts.idx_done) begin
               cmd.push_write = !sts.is_query;
            end else begin
               cmd.ent_rd_key = 1'b1;
               cmd.idx_inc    = 1'b1;
            end
         end
         bfs_pkg::ST_K_CMP: begin
            cmd.set_found = sts.match && sts.is_query;
         end
         bfs_pkg::ST_DONE: begin
            cmd.out_load = !sts.rsp_busy;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

FILE: sv/bfs_dp.sv
module bfs_dp #(
   parameter int MAX_BUCKETS     = 64,
   parameter int PAGE_DEPTH      = 16,
   parameter int INITIAL_BUCKETS = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_type,
   input  logic [31:0]      req_fp,
   input  logic             csr_wr_en,
   input  logic [4:0]       csr_wr_data,
   input  logic             rsp_tready,
   output logic             rsp_tvalid,
   output logic             rsp_found,
   output logic             rsp_failed,
   output logic [6:0]       rsp_count,
   input  bfs_pkg::cmd_type cmd,
   output bfs_pkg::sts_type sts
);

   localparam int FW   = $clog2(PAGE_DEPTH + 1);
   localparam int CAPW = (FW > 5) ? FW : 5;
   localparam int HW   = CAPW + 4;
   localparam int IW   = (PAGE_DEPTH > 1) ? $clog2(PAGE_DEPTH) : 1;
   localparam int BIDX = $clog2(MAX_BUCKETS);
   localparam int BCW  = $clog2(MAX_BUCKETS + 1);
   localparam int EAW  = $clog2(MAX_BUCKETS * PAGE_DEPTH);
   localparam int FDEPTH = 2 * MAX_BUCKETS;
   localparam int EDEPTH = 2 * (2 ** EAW);

   // Memories: the bank bit is the top address bit.
   logic [FW-1:0] fill_mem [FDEPTH];
   logic [FDEPTH-1:0] fill_valid_ff;
   logic [31:0] ent_mem [EDEPTH];

   logic [4:0]      csr_ff;
   logic            type_ff;
   logic [31:0]     fp_ff;
   logic            sel_ff;
   logic [BCW-1:0]  count_ff;
   logic [BIDX-1:0] bkt_ff;
   logic [FW-1:0]   idx_ff;
   logic [FW-1:0]   n_ff;
   logic [FW-1:0]   lo_ff;
   logic [FW-1:0]   hi_ff;
   logic [FW-1:0]   fill_rd_ff;
   logic [31:0]     ent_rd_ff;
   logic            found_ff;
   logic            fail_ff;
   logic            rsp_valid_ff;
   logic            rsp_found_ff;
   logic            rsp_failed_ff;
   logic [6:0]      rsp_count_ff;

   logic [CAPW-1:0] cap_raw;
   logic [CAPW-1:0] cap;
   logic [BIDX-1:0] key;
   logic [BIDX-1:0] oldn;
   logic [BIDX-1:0] fill_rd_bkt;
   logic [BIDX:0]   fill_rd_addr;
   logic [BIDX:0]   fill_wr_addr;
   logic [FW-1:0]   fill_wr_data;
   logic            fill_wr;
   logic [EAW:0]    ent_rd_addr;
   logic [EAW:0]    ent_wr_addr;
   logic [31:0]     ent_wr_data;
   logic            ent_wr;
   logic            grow_hi;
   logic [BIDX-1:0] grow_bkt;
   logic [FW-1:0]   grow_cnt;
   logic            grow_room;

   function automatic logic [EAW:0] ent_addr(input logic bank, input logic [BIDX-1:0] b,
                                             input logic [IW-1:0] slot);
      logic [EAW-1:0] a;
      a = EAW'(EAW'(b) * EAW'(PAGE_DEPTH) + EAW'(slot));
      return {bank, a};
   endfunction

   assign cap_raw = CAPW'(csr_ff);
   assign cap = (cap_raw == '0) ? CAPW'(1) :
                (cap_raw > CAPW'(PAGE_DEPTH)) ? CAPW'(PAGE_DEPTH) : cap_raw;

   assign key  = fp_ff[BIDX-1:0] & BIDX'(count_ff - BCW'(1));
   assign oldn = BIDX'(count_ff);

   assign fill_rd_bkt  = cmd.fill_rd_key ? key : bkt_ff;
   assign fill_rd_addr = {sel_ff, fill_rd_bkt};

   assign ent_rd_addr = ent_addr(sel_ff, cmd.ent_rd_key ? key : bkt_ff, idx_ff[IW-1:0]);

   // Redistribution: bucket b splits into b and b + old count.
   assign grow_hi   = (ent_rd_ff[BIDX-1:0] & oldn) != '0;
   assign grow_bkt  = grow_hi ? (bkt_ff | oldn) : bkt_ff;
   assign grow_cnt  = grow_hi ? hi_ff : lo_ff;
   assign grow_room = CAPW'(grow_cnt) < cap;

   always_comb begin
      ent_wr      = 1'b0;
      ent_wr_addr = ent_addr(sel_ff, key, n_ff[IW-1:0]);
      ent_wr_data = fp_ff;
      if (cmd.grow_push) begin
         ent_wr      = grow_room;
         ent_wr_addr = ent_addr(!sel_ff, grow_bkt, grow_cnt[IW-1:0]);
         ent_wr_data = ent_rd_ff;
      end else if (cmd.push_write) begin
         ent_wr = 1'b1;
      end
   end

   always_comb begin
      fill_wr      = 1'b0;
      fill_wr_addr = {sel_ff, key};
      fill_wr_data = FW'(n_ff + FW'(1));
      if (cmd.fill_wr_lo) begin
         fill_wr      = 1'b1;
         fill_wr_addr = {!sel_ff, bkt_ff};
         fill_wr_data = lo_ff;
      end else if (cmd.fill_wr_hi) begin
         fill_wr      = 1'b1;
         fill_wr_addr = {!sel_ff, bkt_ff | oldn};
         fill_wr_data = hi_ff;
      end else if (cmd.push_write) begin
         fill_wr = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fill_wr) begin
         fill_mem[fill_wr_addr] <= fill_wr_data;
      end
      fill_rd_ff <= fill_valid_ff[fill_rd_addr] ? fill_mem[fill_rd_addr] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_valid_ff <= '0;
      end else begin
         if (cmd.grow_begin) begin
            for (int i = 0; i < MAX_BUCKETS; i++) begin
               fill_valid_ff[{!sel_ff, BIDX'(i)}] <= 1'b0;
            end
         end
         if (fill_wr) begin
            fill_valid_ff[fill_wr_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ent_wr) begin
         ent_mem[ent_wr_addr] <= ent_wr_data;
      end
      ent_rd_ff <= ent_mem[ent_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff       <= 5'd16;
         sel_ff       <= 1'b0;
         count_ff     <= BCW'(INITIAL_BUCKETS);
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (cmd.grow_swap) begin
            sel_ff   <= !sel_ff;
            count_ff <= BCW'({1'b0, count_ff} << 1);
         end
         rsp_valid_ff <= cmd.out_load || (rsp_valid_ff && !rsp_tready);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         type_ff  <= req_type;
         fp_ff    <= req_fp;
         found_ff <= 1'b0;
         fail_ff  <= 1'b0;
      end
      if (cmd.set_found) begin
         found_ff <= 1'b1;
      end
      if (cmd.set_fail) begin
         fail_ff <= 1'b1;
      end
      if (cmd.latch || cmd.bkt_clr) begin
         bkt_ff <= '0;
      end else if (cmd.bkt_inc) begin
         bkt_ff <= bkt_ff + BIDX'(1);
      end
      if (cmd.idx_clr) begin
         idx_ff <= '0;
         lo_ff  <= '0;
         hi_ff  <= '0;
      end else begin
         if (cmd.idx_inc) begin
            idx_ff <= idx_ff + FW'(1);
         end
         if (cmd.grow_push && grow_room) begin
            if (grow_hi) begin
               hi_ff <= hi_ff + FW'(1);
            end else begin
               lo_ff <= lo_ff + FW'(1);
            end
         end
      end
      if (cmd.fill_hold) begin
         n_ff <= fill_rd_ff;
      end
      if (cmd.out_load) begin
         rsp_found_ff  <= found_ff;
         rsp_failed_ff <= fail_ff;
         rsp_count_ff  <= 7'(count_ff);
      end
   end

   assign sts.is_query = (type_ff == bfs_pkg::REQ_QUERY);
   assign sts.fill_hot = (HW'(fill_rd_ff) * HW'(10)) >= (HW'(cap) * HW'(9));
   assign sts.last_bkt = (BCW'(bkt_ff) + BCW'(1)) == count_ff;
   assign sts.idx_done = idx_ff >= n_ff;
   assign sts.match    = ent_rd_ff == fp_ff;
   assign sts.full     = CAPW'(n_ff) >= cap;
   assign sts.grow_ok  = ({1'b0, count_ff} << 1) <= (BCW + 1)'(MAX_BUCKETS);
   assign sts.rsp_busy = rsp_valid_ff && !rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_failed = rsp_failed_ff;
   assign rsp_count  = rsp_count_ff;

endmodule

FILE: verif/bucketed_fingerprint_set_checker.sv
module bucketed_fingerprint_set_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [4:0]  csr_wr_data,
   output int          fail_count,
   output int          pending_count
);

   localparam int NBKT = 64;
   localparam int DEPTH = 16;

   // Packed from the top bit down, so found lands in bit 0 like on the bus.
   typedef struct packed {
      logic [6:0] buckets;
      logic       failed;
      logic       found;
   } outcome_t;

   logic [31:0] slots [NBKT][DEPTH];
   int          fill [NBKT];
   int          nbuckets;
   logic [4:0]  capacity;
   outcome_t    awaited [$];

   function automatic int usable_cap();
      int c;
      c = capacity;
      if (c < 1) c = 1;
      if (c > DEPTH) c = DEPTH;
      return c;
   endfunction

   function automatic bit holds(int b, logic [31:0] fp);
      for (int i = 0; i < fill[b] && i < DEPTH; i++)
         if (slots[b][i] == fp) return 1;
      return 0;
   endfunction

   // Returns 1 when the bucket is already full.
   function automatic bit place(int b, logic [31:0] fp);
      if (fill[b] >= usable_cap()) return 1;
      if (holds(b, fp)) return 0;
      slots[b][fill[b]] = fp;
      fill[b]++;
      return 0;
   endfunction

   function automatic outcome_t apply_request(logic is_query, logic [31:0] fp);
      outcome_t o;
      bit hot;
      logic [31:0] prev_slots [NBKT][DEPTH];
      int prev_fill [NBKT];
      int oldn;
      o = '0;
      if (is_query == bfs_pkg::REQ_QUERY) begin
         o.found = holds(fp % nbuckets, fp);
      end else begin
         hot = 0;
         for (int b = 0; b < nbuckets; b++)
            if (fill[b] * 10 >= usable_cap() * 9) hot = 1;
         if (hot && nbuckets * 2 > NBKT) begin
            o.failed = 1;
         end else begin
            if (hot) begin
               prev_slots = slots;
               prev_fill = fill;
               oldn = nbuckets;
               nbuckets = oldn * 2;
               for (int b = 0; b < NBKT; b++) fill[b] = 0;
               for (int b = 0; b < oldn; b++)
                  for (int j = 0; j < prev_fill[b] && j < DEPTH; j++)
                     void'(place(prev_slots[b][j] % nbuckets, prev_slots[b][j]));
            end
            o.failed = place(fp % nbuckets, fp);
         end
      end
      o.buckets = nbuckets[6:0];
      return o;
   endfunction

   assign pending_count = awaited.size();

   always @(posedge clock) begin
      outcome_t want, got;
      if (reset) begin
         for (int b = 0; b < NBKT; b++) fill[b] = 0;
         nbuckets = 4;
         capacity = 5'd16;
         awaited.delete();
         fail_count <= 0;
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         if (req_tvalid && req_tready)
            awaited.push_back(apply_request(req_tuser, req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[8:0];
            if (awaited.size() == 0) begin
               if (fail_count < 10) $display("unexpected result %p", got);
               fail_count <= fail_count + 1;
            end else begin
               want = awaited.pop_front();
               if (want != got || rsp_tdata[15:9] != '0) begin
                  if (fail_count < 10)
                     $display("mismatch: expected %p, got %p (tdata %h)", want, got,
                              rsp_tdata);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

FILE: verif/bucketed_fingerprint_set_top_test.sv
module bucketed_fingerprint_set_top_test;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;
   logic        csr_wr_en;
   logic [4:0]  csr_wr_data;
   int          fail_count;
   int          pending_count;
   int          cycle_count;
   int          stall_mode;

   // The cycle limit is far above the slowest legal run: about 1700 requests,
   // each at worst a scan of all 64 buckets and one full bucket, plus stalls,
   // pauses and the few growth passes.
   localparam int CYCLE_LIMIT = 1500000;

   bucketed_fingerprint_set_top dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   bucketed_fingerprint_set_checker checker_i (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   // The watchdog ends the run if the block hangs.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver switches among steady acceptance, light stalls and heavy
   // stalls, so that back pressure hits every phase of the block's work.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_mode <= 0;
      end else begin
         if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= ($urandom_range(0, 4) == 0);
         endcase
      end
   end

   // Sends one request and holds it until the block takes it.
   task automatic send_request(logic kind, logic [31:0] fp);
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= fp;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic pause_sender();
      req_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clock);
   endtask

   // Waits until every result has come back and the block has settled, so
   // the capacity register may be changed safely.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_capacity(logic [4:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   logic [31:0] recent [$];

   // A random fingerprint: often a repeat of a recent one, so duplicates and
   // hits are common, and often with small values, so few buckets fill up.
   function automatic logic [31:0] pick_fingerprint();
      int r;
      r = $urandom_range(0, 9);
      if (r < 3 && recent.size() != 0) return recent[$urandom_range(0, recent.size() - 1)];
      if (r < 7) return $urandom_range(0, 255);
      return $urandom;
   endfunction

   task automatic random_phase(int count, logic [4:0] cap);
      int burst;
      logic kind;
      logic [31:0] fp;
      drain();
      write_capacity(cap);
      burst = $urandom_range(1, 20);
      for (int i = 0; i < count; i++) begin
         kind = ($urandom_range(0, 2) == 0) ? bfs_pkg::REQ_QUERY : bfs_pkg::REQ_INSERT;
         fp = pick_fingerprint();
         recent.push_back(fp);
         if (recent.size() > 40) void'(recent.pop_front());
         send_request(kind, fp);
         if (--burst == 0) begin
            if ($urandom_range(0, 3) != 0) pause_sender();
            burst = $urandom_range(1, 20);
         end
      end
   endtask

   initial begin
      logic [4:0] caps [8];
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = bfs_pkg::REQ_INSERT;
      csr_wr_en = 1'b0;
      csr_wr_data = '0;
      cycle_count = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: the fingerprint extremes, a duplicate insert, hits and
      // misses, then a tiny capacity so buckets fill and the table grows up
      // to its limit, where inserts must fail.
      send_request(bfs_pkg::REQ_QUERY, 32'h0);
      send_request(bfs_pkg::REQ_INSERT, 32'h0);
      send_request(bfs_pkg::REQ_INSERT, 32'hFFFF_FFFF);
      send_request(bfs_pkg::REQ_INSERT, 32'hFFFF_FFFF);
      send_request(bfs_pkg::REQ_QUERY, 32'hFFFF_FFFF);
      send_request(bfs_pkg::REQ_QUERY, 32'h0);
      send_request(bfs_pkg::REQ_QUERY, 32'hAAAA_5555);
      send_request(bfs_pkg::REQ_INSERT, 32'h5555_AAAA);
      drain();
      // Capacity zero is clamped to one; lowering it below a fill makes that
      // bucket hot, and growth then drops entries that no longer fit.
      write_capacity(5'd0);
      for (int i = 0; i < 12; i++) send_request(bfs_pkg::REQ_INSERT, 32'(i * 4));
      send_request(bfs_pkg::REQ_QUERY, 32'd8);
      drain();
      write_capacity(5'd31);

      // Capacities cycle through the extremes and a few middle values; the
      // table only grows, so later phases run with many buckets.
      caps = '{5'd16, 5'd1, 5'd31, 5'd9, 5'd0, 5'd2, 5'd17, 5'd10};
      for (int p = 0; p < 8; p++) random_phase(210, caps[p]);

      drain();
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
